@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/csvc_pkg.sv @@
// Package for the clock set and view controller.
// Holds action and edit mode codes, view codes and the digit helpers.
package csvc_pkg;

  localparam logic [1:0] ACT_SET   = 2'd0;
  localparam logic [1:0] ACT_NEXT  = 2'd1;
  localparam logic [1:0] ACT_SEC   = 2'd2;
  localparam logic [1:0] ACT_HALF  = 2'd3;

  localparam logic [2:0] EM_VIEW = 3'd0;
  localparam logic [2:0] EM_MIN  = 3'd2;
  localparam logic [2:0] EM_HRS  = 3'd3;
  localparam logic [2:0] EM_DAY  = 3'd4;
  localparam logic [2:0] EM_MON  = 3'd5;
  localparam logic [2:0] EM_YRS  = 3'd6;

  localparam logic [1:0] VIEW_TIME = 2'd0;
  localparam logic [1:0] VIEW_DATE = 2'd1;
  localparam logic [1:0] VIEW_YEAR = 2'd2;
  localparam logic [1:0] VIEW_TEMP = 2'd3;

  localparam logic [1:0] REG_TIME_DWELL  = 2'd0;
  localparam logic [1:0] REG_OTHER_DWELL = 2'd1;

  localparam logic [7:0] DP_BIT = 8'b1000_0000;

  localparam logic [6:0] MINUTE_MAX = 7'd59;
  localparam logic [6:0] HOUR_MAX   = 7'd23;
  localparam logic [6:0] DAY_MAX    = 7'd31;
  localparam logic [6:0] MONTH_MAX  = 7'd12;
  localparam logic [6:0] YEAR_MAX   = 7'd20;

  typedef logic [7:0] seg_t;

  function automatic seg_t seg_of(input logic [3:0] v);
    seg_t s;
    case (v)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      4'd10:   s = 8'h77;
      4'd11:   s = 8'h7C;
      4'd12:   s = 8'h39;
      4'd13:   s = 8'h5E;
      4'd14:   s = 8'h79;
      default: s = 8'h71;
    endcase
    return s;
  endfunction

  // quotient by ten for values below 1024
  function automatic logic [6:0] div10(input logic [9:0] v);
    logic [17:0] p;
    p = {8'd0, v} * 18'd205;
    return p[17:11];
  endfunction

  function automatic logic [3:0] mod10(input logic [9:0] v, input logic [6:0] q);
    logic [9:0] r;
    r = v - ({3'd0, q} * 10'd10);
    return r[3:0];
  endfunction

endpackage

@@ rtl/clock_set_and_view_control_top.sv @@
// Clock set and view controller, top level.
// Depends on csvc_pkg and assert_macros.svh.
//
// Usage: one transaction on the input channel (in_valid/in_ready) carries an
// action (set key, next key, one-second tick, half-second tick) with the RTC
// time, temperature and rotate switch. Each transaction yields exactly one
// result transaction on the output channel (out_valid/out_ready) with four
// segment bytes, a display update flag, an RTC write flag and the held time.
// The result is written into the output register at the edge that accepts
// the transaction. Throughput is one transaction per cycle unless the
// receiver stalls; the state update and frame rendering are a single
// combinational pass between the input handshake and the output register.
// When stalled, the output register holds and in_ready drops until taken.
// Reset clears the edit mode, view, held time, blink phase, countdown and the
// output valid, and loads the dwell registers with 8 and 2.
// The APB port holds time_view_dwell at 0x0 and other_view_dwell at 0x4.
`include "assert_macros.svh"

module clock_set_and_view_control_top
  import csvc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [5:0]  rtc_minute,
  input  logic [4:0]  rtc_hour,
  input  logic [4:0]  rtc_day,
  input  logic [3:0]  rtc_month,
  input  logic [6:0]  rtc_year,
  input  logic [9:0]  temperature,
  input  logic        auto_rotate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  seg_first,
  output logic [7:0]  seg_second,
  output logic [7:0]  seg_third,
  output logic [7:0]  seg_fourth,
  output logic        display_update,
  output logic        rtc_write,
  output logic [5:0]  out_minute,
  output logic [4:0]  out_hour,
  output logic [4:0]  out_day,
  output logic [3:0]  out_month,
  output logic [6:0]  out_year
);

  logic [3:0] time_view_dwell;
  logic [3:0] other_view_dwell;
  logic [2:0] edit_mode, edit_mode_next;
  logic [1:0] view_select, view_select_next;
  logic [5:0] held_minute, held_minute_next;
  logic [4:0] held_hour, held_hour_next;
  logic [4:0] held_day, held_day_next;
  logic [3:0] held_month, held_month_next;
  logic [6:0] held_year, held_year_next;
  logic       blink_phase, blink_phase_next;
  logic [3:0] rotate_countdown, rotate_countdown_next;

  logic       in_fire;
  logic       cfg_write;
  logic [1:0] cfg_index;
  logic       upd, wr;
  seg_t       d0, d1, d2, d3;

  logic [6:0] pair_hi, pair_lo;
  logic [6:0] hi_q, lo_q;
  logic [3:0] hi_r, lo_r;
  logic [15:0] t_prod;
  logic [3:0] t_hund_q, t_hund;
  logic [6:0] t_q10, t_q100;
  logic [3:0] t_tens, t_units;

  assign pready    = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = {1'b0, paddr[2]};

  always_comb begin
    case (cfg_index)
      REG_TIME_DWELL:  prdata = {28'd0, time_view_dwell};
      REG_OTHER_DWELL: prdata = {28'd0, other_view_dwell};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_view_dwell  <= 4'd8;
      other_view_dwell <= 4'd2;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TIME_DWELL:  time_view_dwell  <= pwdata[3:0];
        REG_OTHER_DWELL: other_view_dwell <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // state update
  always_comb begin
    edit_mode_next        = edit_mode;
    view_select_next      = view_select;
    held_minute_next      = held_minute;
    held_hour_next        = held_hour;
    held_day_next         = held_day;
    held_month_next       = held_month;
    held_year_next        = held_year;
    blink_phase_next      = blink_phase;
    rotate_countdown_next = rotate_countdown;
    wr                    = 1'b0;
    upd                   = 1'b0;
    case (action)
      ACT_SET: begin
        if (edit_mode == EM_YRS) begin
          wr             = 1'b1;
          edit_mode_next = EM_VIEW;
        end else if (edit_mode == EM_VIEW) begin
          edit_mode_next = EM_MIN;
        end else begin
          edit_mode_next = edit_mode + 3'd1;
        end
      end
      ACT_NEXT: begin
        case (edit_mode)
          EM_MIN: held_minute_next = ({1'b0, held_minute} == MINUTE_MAX) ? 6'd0
                                     : held_minute + 6'd1;
          EM_HRS: held_hour_next = ({2'b0, held_hour} == HOUR_MAX) ? 5'd0
                                   : held_hour + 5'd1;
          EM_DAY: held_day_next = ({2'b0, held_day} == DAY_MAX) ? 5'd1
                                  : held_day + 5'd1;
          EM_MON: held_month_next = ({3'b0, held_month} == MONTH_MAX) ? 4'd1
                                    : held_month + 4'd1;
          EM_YRS: held_year_next = (held_year == YEAR_MAX) ? 7'd0
                                   : held_year + 7'd1;
          default: begin
            wr               = 1'b1;
            view_select_next = view_select + 2'd1;
          end
        endcase
      end
      ACT_SEC: begin
        if (edit_mode == EM_VIEW) begin
          upd = 1'b1;
          if (view_select != VIEW_TEMP) begin
            held_minute_next = rtc_minute;
            held_hour_next   = rtc_hour;
            held_day_next    = rtc_day;
            held_month_next  = rtc_month;
            held_year_next   = rtc_year;
          end
          if (auto_rotate) begin
            if (rotate_countdown == 4'd0) begin
              view_select_next      = view_select + 2'd1;
              rotate_countdown_next = (view_select_next == VIEW_TIME) ? time_view_dwell
                                      : other_view_dwell;
            end else begin
              rotate_countdown_next = rotate_countdown - 4'd1;
            end
          end
        end
      end
      default: begin
        if (edit_mode != EM_VIEW) begin
          upd              = 1'b1;
          blink_phase_next = !blink_phase;
        end
      end
    endcase
  end

  // digit split
  always_comb begin
    if (action == ACT_SEC) begin
      case (view_select)
        VIEW_TIME: begin
          pair_hi = {2'b0, held_hour_next};
          pair_lo = {1'b0, held_minute_next};
        end
        VIEW_DATE: begin
          pair_hi = {2'b0, held_day_next};
          pair_lo = {3'b0, held_month_next};
        end
        default: begin
          pair_hi = YEAR_MAX;
          pair_lo = held_year_next;
        end
      endcase
    end else begin
      case (edit_mode)
        EM_MIN, EM_HRS: begin
          pair_hi = {2'b0, held_hour_next};
          pair_lo = {1'b0, held_minute_next};
        end
        EM_DAY, EM_MON: begin
          pair_hi = {2'b0, held_day_next};
          pair_lo = {3'b0, held_month_next};
        end
        default: begin
          pair_hi = YEAR_MAX;
          pair_lo = held_year_next;
        end
      endcase
    end
  end

  assign hi_q = div10({3'd0, pair_hi});
  assign lo_q = div10({3'd0, pair_lo});
  assign hi_r = mod10({3'd0, pair_hi}, hi_q);
  assign lo_r = mod10({3'd0, pair_lo}, lo_q);

  assign t_prod   = {6'd0, temperature} * 16'd41;
  assign t_hund_q = t_prod[15:12];
  assign t_hund   = (t_hund_q >= 4'd10) ? t_hund_q - 4'd10 : t_hund_q;
  assign t_q10    = div10(temperature);
  assign t_q100   = div10({3'd0, t_q10});
  assign t_tens   = mod10({3'd0, t_q10}, t_q100);
  assign t_units  = mod10(temperature, t_q10);

  // frame rendering
  always_comb begin
    d0 = seg_of(hi_q[3:0]);
    d1 = seg_of(hi_r);
    d2 = seg_of(lo_q[3:0]);
    d3 = seg_of(lo_r);
    if (action == ACT_SEC) begin
      case (view_select)
        VIEW_TIME: d1 = d1 | DP_BIT;
        VIEW_DATE: begin
          d1 = d1 | DP_BIT;
          d3 = d3 | DP_BIT;
        end
        VIEW_TEMP: begin
          d0 = 8'd0;
          d1 = seg_of(t_hund);
          d2 = seg_of(t_tens) | DP_BIT;
          d3 = seg_of(t_units);
        end
        default: ;
      endcase
    end else begin
      case (edit_mode)
        EM_MIN, EM_HRS: d1 = d1 | DP_BIT;
        EM_DAY, EM_MON: begin
          d1 = d1 | DP_BIT;
          d3 = d3 | DP_BIT;
        end
        EM_YRS: ;
        default: begin
          d0 = 8'd0;
          d1 = 8'd0;
          d2 = 8'd0;
          d3 = 8'd0;
        end
      endcase
      if (!blink_phase) begin
        if (edit_mode == EM_HRS || edit_mode == EM_DAY) begin
          d0 = 8'd0;
          d1 = 8'd0;
        end else begin
          d2 = 8'd0;
          d3 = 8'd0;
        end
      end
    end
    if (!upd) begin
      d0 = 8'd0;
      d1 = 8'd0;
      d2 = 8'd0;
      d3 = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edit_mode        <= EM_VIEW;
      view_select      <= VIEW_TIME;
      held_minute      <= 6'd0;
      held_hour        <= 5'd0;
      held_day         <= 5'd0;
      held_month       <= 4'd0;
      held_year        <= 7'd0;
      blink_phase      <= 1'b0;
      rotate_countdown <= 4'd0;
      out_valid        <= 1'b0;
    end else begin
      if (in_fire) begin
        edit_mode        <= edit_mode_next;
        view_select      <= view_select_next;
        held_minute      <= held_minute_next;
        held_hour        <= held_hour_next;
        held_day         <= held_day_next;
        held_month       <= held_month_next;
        held_year        <= held_year_next;
        blink_phase      <= blink_phase_next;
        rotate_countdown <= rotate_countdown_next;
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      seg_first      <= d0;
      seg_second     <= d1;
      seg_third      <= d2;
      seg_fourth     <= d3;
      display_update <= upd;
      rtc_write      <= wr;
      out_minute     <= held_minute_next;
      out_hour       <= held_hour_next;
      out_day        <= held_day_next;
      out_month      <= held_month_next;
      out_year       <= held_year_next;
    end
  end

  `ASSERT_IMPLY(a_write_no_frame, clk, rst, out_valid && rtc_write, !display_update)
  `ASSERT_IMPLY(a_blank_without_update, clk, rst, out_valid && !display_update,
    seg_first == 8'd0 && seg_second == 8'd0 && seg_third == 8'd0 && seg_fourth == 8'd0)
  `ASSERT_NEXT(a_year_exit_writes, clk, rst,
    in_fire && action == ACT_SET && edit_mode == EM_YRS,
    out_valid && rtc_write && edit_mode == EM_VIEW)

endmodule
